FILE: rtl/atrsp_pkg.sv
// Shared types and constants of the AT response stream parser.
package atrsp_pkg;

  // Line buffer length: longest line kept and the payload size limit.
  localparam int LINE_BUF_LEN = 256;
  localparam int LINE_W       = $clog2(LINE_BUF_LEN);

  // Signed length accumulator and its clamp limits.
  localparam int ACC_W = 16;
  localparam logic signed [ACC_W-1:0] LEN_MAX   = 16'sd32767;
  localparam logic signed [ACC_W-1:0] LEN_MIN   = -16'sd32767;
  localparam logic signed [ACC_W-1:0] LEN_LIMIT = ACC_W'(LINE_BUF_LEN);

  // Result kinds.
  localparam logic [2:0] EVT_OK       = 3'd0;
  localparam logic [2:0] EVT_BUSY_OK  = 3'd1;
  localparam logic [2:0] EVT_ERROR    = 3'd2;
  localparam logic [2:0] EVT_PAYLOAD  = 3'd3;
  localparam logic [2:0] EVT_OVERSIZE = 3'd4;

  // Event queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } event_t;

endpackage

FILE: rtl/atrsp_front.sv
// Byte classifier: line tail matching, length parsing and payload counting.
module atrsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  logic [7:0]          in_byte,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                push,
  output atrsp_pkg::event_t   push_evt
);

  localparam logic [1:0] MODE_LINE      = 2'd0;
  localparam logic [1:0] MODE_LEN_FIRST = 2'd1;
  localparam logic [1:0] MODE_LEN_MORE  = 2'd2;
  localparam logic [1:0] MODE_PAYLOAD   = 2'd3;

  localparam logic [31:0] PAT_OK     = 32'h4F4B0D0A;
  localparam logic [55:0] PAT_ERROR  = 56'h4552524F520D0A;
  localparam logic [31:0] PAT_BUSY   = 32'h62757379;
  localparam logic [55:0] PAT_SENDOK = 56'h53454E44204F4B;
  localparam logic [39:0] PAT_IPD    = 40'h2B4950442C;

  logic                                pending_r, pending_nxt;
  logic [55:0]                         tail_r, tail_nxt;
  logic [atrsp_pkg::LINE_W-1:0]        count_r, count_nxt;
  logic [1:0]                          mode_r, mode_nxt;
  logic signed [atrsp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [atrsp_pkg::LINE_W-1:0]        left_r, left_nxt;
  logic                                busy_r, busy_nxt;
  logic                                sendok_r, sendok_nxt;
  logic                                prompt_r, prompt_nxt;

  logic [55:0]                         tail_sh;
  logic                                prev_cr;
  logic signed [20:0]                  acc_ext;
  logic signed [20:0]                  acc_sum;
  logic [atrsp_pkg::LINE_W-1:0]        left_dec;
  logic [atrsp_pkg::LINE_W:0]          count_inc;

  assign tail_sh   = {tail_r[47:0], in_byte};
  assign prev_cr   = (count_r != '0) && (tail_r[7:0] == 8'h0D);
  assign acc_ext   = 21'(acc_r);
  assign acc_sum   = (acc_ext <<< 3) + (acc_ext <<< 1)
                   + $signed({13'd0, in_byte}) - 21'sd48;
  assign left_dec  = (left_r == '0) ? '0 : left_r - 1'b1;
  assign count_inc = {1'b0, count_r} + 1'b1;

  always_comb begin
    pending_nxt = cfg_wr_en ? cfg_wr_data : pending_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    mode_nxt    = mode_r;
    acc_nxt     = acc_r;
    left_nxt    = left_r;
    busy_nxt    = busy_r;
    sendok_nxt  = sendok_r;
    prompt_nxt  = prompt_r;
    push        = 1'b0;
    push_evt    = '0;

    if (in_take) begin
      unique case (mode_r) inside
        MODE_LEN_FIRST, MODE_LEN_MORE: begin
          if (mode_r == MODE_LEN_MORE && in_byte == 8'h3A) begin
            // End of length: clear the line and decide what follows.
            mode_nxt   = MODE_LINE;
            tail_nxt   = '0;
            count_nxt  = '0;
            busy_nxt   = 1'b0;
            sendok_nxt = 1'b0;
            prompt_nxt = 1'b0;
            acc_nxt    = '0;
            if (acc_r >= atrsp_pkg::LEN_LIMIT) begin
              push          = 1'b1;
              push_evt.kind = atrsp_pkg::EVT_OVERSIZE;
            end else if (acc_r > 0) begin
              left_nxt = acc_r[atrsp_pkg::LINE_W-1:0];
              mode_nxt = MODE_PAYLOAD;
            end
          end else begin
            if (acc_sum > 21'(atrsp_pkg::LEN_MAX)) begin
              acc_nxt = atrsp_pkg::LEN_MAX;
            end else if (acc_sum < 21'(atrsp_pkg::LEN_MIN)) begin
              acc_nxt = atrsp_pkg::LEN_MIN;
            end else begin
              acc_nxt = acc_sum[atrsp_pkg::ACC_W-1:0];
            end
            mode_nxt = MODE_LEN_MORE;
          end
        end
        MODE_PAYLOAD: begin
          push          = 1'b1;
          push_evt.kind = atrsp_pkg::EVT_PAYLOAD;
          push_evt.data = in_byte;
          push_evt.last = (left_r <= 1);
          left_nxt      = left_dec;
          if (left_dec == '0) begin
            mode_nxt   = MODE_LINE;
            tail_nxt   = '0;
            count_nxt  = '0;
            busy_nxt   = 1'b0;
            sendok_nxt = 1'b0;
            prompt_nxt = 1'b0;
          end
        end
        default: begin
          if (count_r == '0) begin
            prompt_nxt = (in_byte == 8'h3E);
          end
          tail_nxt = tail_sh;
          if (tail_sh[31:0] == PAT_BUSY) begin
            busy_nxt = 1'b1;
          end
          if (tail_sh == PAT_SENDOK) begin
            sendok_nxt = 1'b1;
          end
          if (in_byte == 8'h0A && prev_cr) begin
            if (tail_sh[31:0] == PAT_OK) begin
              push          = 1'b1;
              push_evt.kind = (busy_nxt && sendok_nxt && !(pending_r && prompt_nxt))
                            ? atrsp_pkg::EVT_BUSY_OK : atrsp_pkg::EVT_OK;
            end else if (tail_sh == PAT_ERROR) begin
              push          = 1'b1;
              push_evt.kind = atrsp_pkg::EVT_ERROR;
            end
            tail_nxt   = '0;
            count_nxt  = '0;
            busy_nxt   = 1'b0;
            sendok_nxt = 1'b0;
            prompt_nxt = 1'b0;
          end else if (tail_sh[39:0] == PAT_IPD) begin
            tail_nxt   = '0;
            count_nxt  = '0;
            busy_nxt   = 1'b0;
            sendok_nxt = 1'b0;
            prompt_nxt = 1'b0;
            mode_nxt   = MODE_LEN_FIRST;
            acc_nxt    = '0;
          end else if (count_inc >= (atrsp_pkg::LINE_W + 1)'(atrsp_pkg::LINE_BUF_LEN)) begin
            // Line overflow: restart collection.
            tail_nxt   = '0;
            count_nxt  = '0;
            busy_nxt   = 1'b0;
            sendok_nxt = 1'b0;
            prompt_nxt = 1'b0;
          end else begin
            count_nxt = count_inc[atrsp_pkg::LINE_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      tail_r    <= '0;
      count_r   <= '0;
      mode_r    <= MODE_LINE;
      acc_r     <= '0;
      left_r    <= '0;
      busy_r    <= 1'b0;
      sendok_r  <= 1'b0;
      prompt_r  <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
      busy_r    <= busy_nxt;
      sendok_r  <= sendok_nxt;
      prompt_r  <= prompt_nxt;
    end
  end

endmodule

FILE: rtl/atrsp_queue.sv
// Short event queue between the classifier and the output stage.
module atrsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  atrsp_pkg::event_t  push_evt,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output atrsp_pkg::event_t  head_evt
);

  atrsp_pkg::event_t                 mem_r [atrsp_pkg::QUEUE_DEPTH];
  logic [atrsp_pkg::QPTR_W-1:0]      wptr_r, wptr_nxt;
  logic [atrsp_pkg::QPTR_W-1:0]      rptr_r, rptr_nxt;
  logic [atrsp_pkg::QPTR_W:0]        cnt_r, cnt_nxt;

  assign full      = (cnt_r == (atrsp_pkg::QPTR_W + 1)'(atrsp_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_evt  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + {{atrsp_pkg::QPTR_W{1'b0}}, push} - {{atrsp_pkg::QPTR_W{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/atrsp_back.sv
// Output register stage: drain the event queue onto the result channel.
module atrsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  atrsp_pkg::event_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output atrsp_pkg::event_t  out_evt
);

  logic              valid_r, valid_nxt;
  atrsp_pkg::event_t evt_r;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_evt   = evt_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      evt_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

FILE: rtl/at_response_stream_parser.sv
// Top level of the AT response stream parser.
//
// Usage:
//   Input channel (in_*): one received modem byte per transfer in in_tdata.
//   Result channel (out_*): one event per transfer; out_tdata carries the
//   event kind and payload byte, out_tlast flags the final payload byte.
//   cfg_wr_en/cfg_wr_data write the send-prompt-pending flag; write it only
//   while the block is idle.
// Throughput: one byte per cycle while in_tready is high. The classifier
//   updates the whole line and length state for a byte in the cycle of its transfer.
// Event path: the queue is written at the edge of the input transfer, and the
//   output register loads the event once the register is empty or its event is
//   taken; out_tvalid then rises and the result transfers while out_tready is high.
// Reset (rst_n low, synchronous): clear line state, return to line mode,
//   empty the queue and drop any held event; the flag resets to zero.
// Stall: while out_tready is low the output register holds its event and
//   the four-entry queue keeps filling; in_tready falls only when the queue
//   is full, so bytes that cause no event are held back as well.
module at_response_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] event_kind, [10:3] payload_byte, rest zero
  output logic        out_tlast,  // payload_last
  // Configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data // send_prompt_pending
);

  logic              in_take;
  logic              push;
  atrsp_pkg::event_t push_evt;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  atrsp_pkg::event_t q_head;
  atrsp_pkg::event_t out_evt;

  // Accept while the queue has room.
  assign in_tready = !q_full;
  assign in_take   = in_tvalid && in_tready;

  atrsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (in_take),
    .in_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_evt    (push_evt)
  );

  atrsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_evt  (push_evt),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_evt  (q_head)
  );

  atrsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_evt     (out_evt)
  );

  // Pack the result fields, kind in the lowest bits.
  assign out_tdata = {5'd0, out_evt.data, out_evt.kind};
  assign out_tlast = out_evt.last;

endmodule

FILE: verif/tb_at_response_stream_parser.sv
// Self-checking testbench of the AT response stream parser: directed and random byte traffic.
module tb_at_response_stream_parser;

  // Character codes used by the parser and by the traffic generators.
  localparam logic [7:0] CR        = 8'h0D;
  localparam logic [7:0] LF        = 8'h0A;
  localparam logic [7:0] COLON     = 8'h3A;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] PROMPT    = 8'h3E;
  localparam logic [7:0] FILL_CHAR = 8'h78;

  // Line tail patterns, most recent byte in the lowest bits.
  localparam logic [31:0] PAT_OK      = 32'h4F4B_0D0A;
  localparam logic [55:0] PAT_ERROR   = 56'h45_5252_4F52_0D0A;
  localparam logic [31:0] PAT_BUSY    = 32'h6275_7379;
  localparam logic [55:0] PAT_SEND_OK = 56'h53_454E_4420_4F4B;
  localparam logic [39:0] PAT_IPD     = 40'h2B_4950_442C;

  localparam int DRAIN_CYCLES  = 4;     // event latency plus margin
  localparam int RANDOM_ITEMS  = 200;
  localparam int RANDOM_PHASES = 4;

  typedef enum logic [1:0] {ST_LINE, ST_LEN_FIRST, ST_LEN_MORE, ST_PAYLOAD} parse_mode_t;
  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_style_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // [2:0] event_kind, [10:3] payload_byte, rest zero
  logic        out_tlast;          // payload_last
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0; // send_prompt_pending

  at_response_stream_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Parser state as the predictor sees it; starts at the reset values.
  logic [55:0]  line_tail      = '0;
  int           line_len       = 0;
  logic         has_busy       = 1'b0;
  logic         has_send_ok    = 1'b0;
  logic         starts_prompt  = 1'b0;
  parse_mode_t  rx_mode        = ST_LINE;
  int           len_acc        = 0;
  int           bytes_left     = 0;
  logic         prompt_pending = 1'b0;

  atrsp_pkg::event_t due_events[$];   // events predicted but not yet seen on the result channel
  atrsp_pkg::event_t head_event;

  int mismatches     = 0;
  int sent_count     = 0;
  int events_checked = 0;
  int kind_count[8];
  int burst_left     = 0;

  rx_style_t rx_style  = RX_FREE;
  int        rx_span   = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void queue_event(input logic [2:0] kind, input logic [7:0] data,
                                      input logic last);
    due_events.push_back('{kind: kind, data: data, last: last});
  endfunction

  function automatic void clear_line_state();
    line_tail     = '0;
    line_len      = 0;
    has_busy      = 1'b0;
    has_send_ok   = 1'b0;
    starts_prompt = 1'b0;
  endfunction

  // Advance the predicted parser by one received byte and queue any event it causes.
  function automatic void parse_modem_byte(input logic [7:0] b);
    int   v;
    logic prev_cr;
    case (rx_mode)
      ST_LEN_FIRST, ST_LEN_MORE: begin
        // A colon closes the length only after the first length character.
        if (rx_mode == ST_LEN_MORE && b == COLON) begin
          rx_mode = ST_LINE;
          clear_line_state();
          if (len_acc >= atrsp_pkg::LINE_BUF_LEN) begin
            queue_event(atrsp_pkg::EVT_OVERSIZE, 8'h00, 1'b0);
          end else if (len_acc > 0) begin
            bytes_left = len_acc;
            rx_mode    = ST_PAYLOAD;
          end
          len_acc = 0;
        end else begin
          // Every byte counts as a digit, offset from '0'; clamp to the accumulator range.
          v = len_acc * 10 + (int'(b) - int'(CHAR_0));
          if (v > int'(atrsp_pkg::LEN_MAX)) v = int'(atrsp_pkg::LEN_MAX);
          if (v < int'(atrsp_pkg::LEN_MIN)) v = int'(atrsp_pkg::LEN_MIN);
          len_acc = v;
          rx_mode = ST_LEN_MORE;
        end
      end
      ST_PAYLOAD: begin
        queue_event(atrsp_pkg::EVT_PAYLOAD, b, bytes_left <= 1);
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) begin
          rx_mode = ST_LINE;
          clear_line_state();
        end
      end
      default: begin
        prev_cr = (line_len > 0) && (line_tail[7:0] == CR);
        if (line_len == 0) starts_prompt = (b == PROMPT);
        line_tail = {line_tail[47:0], b};
        if (line_tail[31:0] == PAT_BUSY) has_busy = 1'b1;
        if (line_tail == PAT_SEND_OK) has_send_ok = 1'b1;
        if (b == LF && prev_cr) begin
          if (line_tail[31:0] == PAT_OK) begin
            // A prompt line under a pending send is a plain ok even with busy seen.
            if (has_busy && has_send_ok && !(prompt_pending && starts_prompt))
              queue_event(atrsp_pkg::EVT_BUSY_OK, 8'h00, 1'b0);
            else
              queue_event(atrsp_pkg::EVT_OK, 8'h00, 1'b0);
          end else if (line_tail == PAT_ERROR) begin
            queue_event(atrsp_pkg::EVT_ERROR, 8'h00, 1'b0);
          end
          clear_line_state();
        end else if (line_tail[39:0] == PAT_IPD) begin
          clear_line_state();
          rx_mode = ST_LEN_FIRST;
          len_acc = 0;
        end else if (line_len + 1 >= atrsp_pkg::LINE_BUF_LEN) begin
          // Line too long: drop what was collected and start over.
          clear_line_state();
        end else begin
          line_len++;
        end
      end
    endcase
  endfunction

  // Predict from every accepted input transfer.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) parse_modem_byte(in_tdata);
  end

  // Compare every accepted output transfer with the oldest predicted event.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("event with none predicted, tdata %h tlast %b",
                                  out_tdata, out_tlast));
      end else begin
        head_event = due_events.pop_front();
        if (out_tdata[2:0] !== head_event.kind)
          report_mismatch($sformatf("event_kind %0d, predicted %0d",
                                    out_tdata[2:0], head_event.kind));
        if (out_tdata[10:3] !== head_event.data)
          report_mismatch($sformatf("payload_byte %h, predicted %h (kind %0d)",
                                    out_tdata[10:3], head_event.data, head_event.kind));
        if (out_tlast !== head_event.last)
          report_mismatch($sformatf("payload_last %b, predicted %b (kind %0d)",
                                    out_tlast, head_event.last, head_event.kind));
        events_checked++;
        kind_count[head_event.kind]++;
      end
    end
  end

  // Receiver back-pressure: switch between stall styles after spans of random
  // length, including stretches of constant readiness.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_span  = $urandom_range(16, 96);
    end else begin
      rx_span--;
    end
    case (rx_style)
      RX_FREE:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= rx_span[3];
    endcase
  end

  // Send one byte and hold it until the transfer; the sender runs in bursts
  // of random length and drops valid for a random gap between them.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_tdata  <= b;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(0, 16);
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CR);
    send_byte(LF);
  endtask

  task automatic send_filler(input int count);
    repeat (count) send_byte(8'($urandom_range(32, 126)));
  endtask

  task automatic send_payload(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stop sending, wait for every predicted event, then let in-flight bytes settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_prompt_pending(input logic value);
    wait_drained();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    prompt_pending = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Plain ok and error lines, dropped lines, stray line feeds and byte extremes.
  task automatic test_result_lines();
    set_prompt_pending(1'b0);
    send_line("OK");
    send_line("ERROR");
    send_line("AT");
    send_byte(LF);                        // line feed opening a line is no line end
    send_text("OK");
    send_byte(LF);                        // line feed without carriage return
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("OK");
  endtask

  // Busy-ok lines with and without a leading prompt, under both flag values.
  task automatic test_busy_ok();
    send_line("busy p...SEND OK");
    send_line(">busy SEND OK");
    set_prompt_pending(1'b1);
    send_line(">busy SEND OK");           // prompt line under a pending send: plain ok
    send_line("busy SEND OK");
    send_line("SEND OK");
  endtask

  // Data frames: short and longest payloads, empty, negative, oversize and
  // saturated lengths, and a colon taken as the first length digit.
  task automatic test_data_frames();
    send_text("+IPD,3:abc");
    send_text("+IPD,1:");
    send_byte(8'hFF);
    send_text("+IPD,0:");
    send_text("+IPD,-5:");
    send_text("+IPD,256:");
    send_text("+IPD,99999:");
    send_text("+IPD,//////:");            // drives the accumulator to its negative limit
    send_text("+IPD,::");                 // first colon counts as ten
    send_payload(10);
    send_text("+IPD,255:");
    send_payload(255);
    send_line("OK");
  endtask

  // A line that just fits keeps its ending; one byte more and the carriage
  // return lands on the clearing step, so the ok is lost.
  task automatic test_line_overflow();
    repeat (atrsp_pkg::LINE_BUF_LEN - 4) send_byte(FILL_CHAR);
    send_line("OK");
    repeat (atrsp_pkg::LINE_BUF_LEN - 3) send_byte(FILL_CHAR);
    send_line("OK");
  endtask

  task automatic send_reply_line();
    int pick;
    if ($urandom_range(0, 2) == 0) send_filler($urandom_range(1, 6));
    pick = $urandom_range(0, 3);
    case (pick)
      0:       send_text("OK");
      1:       send_text("ERROR");
      2:       send_filler($urandom_range(1, 10));
      default: ;
    endcase
    send_byte(CR);
    if ($urandom_range(0, 9) != 0) send_byte(LF);
  endtask

  task automatic send_busy_line();
    if ($urandom_range(0, 1) == 0) send_byte(PROMPT);
    send_filler($urandom_range(0, 3));
    if ($urandom_range(0, 4) != 0) send_text("busy");
    send_filler($urandom_range(0, 3));
    if ($urandom_range(0, 4) != 0) send_text("SEND OK");
    else send_text("OK");
    send_byte(CR);
    send_byte(LF);
  endtask

  // Data frame with random header and content; broken ones have a garbage
  // length, a payload cut short, or a header abandoned for a reply line.
  task automatic send_data_frame(input bit well_formed);
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      n = $urandom_range(1, 16);
    else if (pick < 80) n = $urandom_range(17, 80);
    else if (pick < 83) n = $urandom_range(200, 255);
    else if (pick < 88) n = $urandom_range(256, 99999);
    else                n = 0 - int'($urandom_range(0, 40));
    if ($urandom_range(0, 3) == 0) begin
      send_byte(CR);
      send_byte(LF);
    end else if ($urandom_range(0, 3) == 0) begin
      send_filler($urandom_range(1, 4));
    end
    send_text("+IPD,");
    if (well_formed) begin
      send_text($sformatf("%0d", n));
      send_byte(COLON);
      if (n > 0 && n < atrsp_pkg::LINE_BUF_LEN) send_payload(n);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          send_byte(COLON);
        end
        1: begin
          send_text($sformatf("%0d", n));
          send_byte(COLON);
          if (n > 1 && n < atrsp_pkg::LINE_BUF_LEN) send_payload($urandom_range(0, n - 1));
        end
        default: begin
          send_text($sformatf("%0d", n));
          send_reply_line();
          send_byte(COLON);
        end
      endcase
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed replies and frames with random content, some noise and
  // broken frames; the prompt flag alternates between phases.
  task automatic test_random_traffic();
    int phase_end;
    int pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_prompt_pending(p[0]);
      phase_end = sent_count + RANDOM_ITEMS / RANDOM_PHASES;
      while (sent_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      send_reply_line();
        else if (pick < 65) send_data_frame(1'b1);
        else if (pick < 80) send_busy_line();
        else if (pick < 90) send_noise();
        else                send_data_frame(1'b0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_result_lines();
    test_busy_ok();
    test_data_frames();
    test_line_overflow();
    test_random_traffic();
    wait_drained();
    $display("Drove %0d bytes: reply, busy and prompt lines, data frames, odd lengths, %s",
             sent_count, "line overflow and noise, with the prompt flag at 0 and 1.");
    $display("Checked %0d events: ok %0d, busy-ok %0d, error %0d, payload %0d, oversize %0d.",
             events_checked, kind_count[atrsp_pkg::EVT_OK],
             kind_count[atrsp_pkg::EVT_BUSY_OK], kind_count[atrsp_pkg::EVT_ERROR],
             kind_count[atrsp_pkg::EVT_PAYLOAD], kind_count[atrsp_pkg::EVT_OVERSIZE]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run of this traffic.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/atrsp_pkg.sv
rtl/atrsp_front.sv
rtl/atrsp_queue.sv
rtl/atrsp_back.sv
rtl/at_response_stream_parser.sv
verif/tb_at_response_stream_parser.sv
